[hw/rtl/wdlt_pkg.sv]
// ----------------------------------------------------------------------------
// wdlt_pkg
// Shared sizes, codes and types for the wait-die lock table.
// ----------------------------------------------------------------------------
package wdlt_pkg;

   localparam int NUM_LOCKS  = 64;
   localparam int STAMP_BITS = 32;

   localparam int ADDR_BITS  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
   localparam int SCAN_BITS  = $clog2(NUM_LOCKS + 1);

   localparam int TYPE_BITS     = 1;
   localparam int INDEX_BITS    = 6;
   localparam int REQ_TS_BITS   = 32;
   localparam int STATUS_BITS   = 2;
   localparam int HOLDER_BITS   = 32;
   localparam int COUNT_BITS    = 7;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 40;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic [TYPE_BITS-1:0] REQ_ACQUIRE = 1'b0;
   localparam logic [TYPE_BITS-1:0] REQ_RELEASE = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_GRANTED  = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_DIE      = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_WAIT     = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_RELEASED = 2'd3;

   typedef enum logic [3:0] {
      FSM_IDLE    = 4'b0001,
      FSM_ACQ     = 4'b0010,
      FSM_REL     = 4'b0100,
      FSM_REL_END = 4'b1000
   } fsm_type;

endpackage

[hw/rtl/wdlt_ram.sv]
// ----------------------------------------------------------------------------
// wdlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wdlt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/wait_die_lock_table.sv]
// ----------------------------------------------------------------------------
// wait_die_lock_table
// Lock table arbitrated by the wait-die rule, owners kept in one RAM.
// ----------------------------------------------------------------------------
// Acquire: the RAM is read at the accepting edge; compare, write back and the
//   registered result follow once the output is free. A new request is taken only once the result is registered.
// Release: sweeps every entry through the RAM read port, then registers the
//   result with the release count once the output is free.
// Reset: synchronous; clears the per-entry valid bits at once, so every lock
//   reads free as soon as reset is released. No clearing sweep.
module wait_die_lock_table (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [wdlt_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // lock_index, requester_ts
   input  logic [wdlt_pkg::TYPE_BITS-1:0]       req_tuser,  // req_type
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [wdlt_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // holder_ts, released_count
   output logic [wdlt_pkg::STATUS_BITS-1:0]     rsp_tuser   // status
);

   localparam int AW = wdlt_pkg::ADDR_BITS;
   localparam int SW = wdlt_pkg::STAMP_BITS;

   wdlt_pkg::fsm_type                        state_ff, state_in;
   logic [wdlt_pkg::INDEX_BITS-1:0]          idx_ff, idx_in;
   logic [SW-1:0]                            ts_ff, ts_in;
   logic [wdlt_pkg::NUM_LOCKS-1:0]           valid_ff, valid_in;
   logic                                     rd_vld_ff, rd_vld_in;
   logic [wdlt_pkg::SCAN_BITS-1:0]           scan_ff, scan_in;
   logic                                     cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]                            cmp_addr_ff, cmp_addr_in;
   logic [wdlt_pkg::COUNT_BITS-1:0]          cnt_ff, cnt_in;
   logic                                     rsp_vld_ff, rsp_vld_in;
   logic [wdlt_pkg::STATUS_BITS-1:0]         status_ff, status_in;
   logic [wdlt_pkg::HOLDER_BITS-1:0]         holder_ff, holder_in;
   logic [wdlt_pkg::COUNT_BITS-1:0]          count_ff, count_in;

   logic                                     req_fire;
   logic                                     out_free;
   logic                                     ram_rd_en;
   logic [AW-1:0]                            ram_rd_addr;
   logic                                     ram_wr_en;
   logic [SW-1:0]                            ram_rd_data;
   logic [SW-1:0]                            cur_stamp;
   logic                                     idx_oob;
   logic [wdlt_pkg::INDEX_BITS-1:0]          req_idx;
   logic [wdlt_pkg::REQ_TS_BITS-1:0]         req_ts;

   assign req_idx    = req_tdata[wdlt_pkg::INDEX_BITS-1:0];
   assign req_ts     = req_tdata[wdlt_pkg::INDEX_BITS +: wdlt_pkg::REQ_TS_BITS];
   assign req_tready = (state_ff == wdlt_pkg::FSM_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign cur_stamp  = rd_vld_ff ? ram_rd_data : '0;
   assign idx_oob    = (32'(idx_ff) >= 32'(wdlt_pkg::NUM_LOCKS));

   wdlt_ram #(
      .WIDTH (SW),
      .DEPTH (wdlt_pkg::NUM_LOCKS)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(idx_ff)),
      .wr_data (ts_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      ts_in       = ts_ff;
      valid_in    = valid_ff;
      scan_in     = scan_ff;
      cmp_vld_in  = 1'b0;
      cmp_addr_in = cmp_addr_ff;
      cnt_in      = cnt_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      status_in   = status_ff;
      holder_in   = holder_ff;
      count_in    = count_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = AW'(req_idx);
      ram_wr_en   = 1'b0;

      unique case (state_ff)
         wdlt_pkg::FSM_IDLE: begin
            if (req_fire) begin
               idx_in = req_idx;
               ts_in  = SW'(req_ts);
               if (req_tuser == wdlt_pkg::REQ_ACQUIRE) begin
                  ram_rd_en = 1'b1;
                  state_in  = wdlt_pkg::FSM_ACQ;
               end else begin
                  scan_in  = '0;
                  cnt_in   = '0;
                  state_in = wdlt_pkg::FSM_REL;
               end
            end
         end
         wdlt_pkg::FSM_ACQ: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               count_in   = '0;
               if (idx_oob) begin
                  status_in = wdlt_pkg::ST_DIE;
                  holder_in = '0;
               end else if (cur_stamp == ts_ff || cur_stamp == '0) begin
                  status_in        = wdlt_pkg::ST_GRANTED;
                  holder_in        = wdlt_pkg::HOLDER_BITS'(ts_ff);
                  ram_wr_en        = 1'b1;
                  valid_in[AW'(idx_ff)] = 1'b1;
               end else if (cur_stamp < ts_ff) begin
                  status_in = wdlt_pkg::ST_DIE;
                  holder_in = wdlt_pkg::HOLDER_BITS'(cur_stamp);
               end else begin
                  status_in = wdlt_pkg::ST_WAIT;
                  holder_in = wdlt_pkg::HOLDER_BITS'(cur_stamp);
               end
               state_in = wdlt_pkg::FSM_IDLE;
            end
         end
         wdlt_pkg::FSM_REL: begin
            ram_rd_addr = scan_ff[AW-1:0];
            if (32'(scan_ff) < 32'(wdlt_pkg::NUM_LOCKS)) begin
               ram_rd_en   = 1'b1;
               cmp_vld_in  = 1'b1;
               cmp_addr_in = scan_ff[AW-1:0];
               scan_in     = scan_ff + 1'b1;
            end
            if (cmp_vld_ff) begin
               if (rd_vld_ff && ram_rd_data == ts_ff && ts_ff != '0) begin
                  valid_in[cmp_addr_ff] = 1'b0;
                  if (cnt_ff != wdlt_pkg::COUNT_MAX) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               if (32'(cmp_addr_ff) == 32'(wdlt_pkg::NUM_LOCKS - 1)) begin
                  state_in = wdlt_pkg::FSM_REL_END;
               end
            end
         end
         wdlt_pkg::FSM_REL_END: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               status_in  = wdlt_pkg::ST_RELEASED;
               holder_in  = '0;
               count_in   = cnt_ff;
               state_in   = wdlt_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = wdlt_pkg::FSM_IDLE;
         end
      endcase

      rd_vld_in = ram_rd_en ? valid_ff[ram_rd_addr] : rd_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= wdlt_pkg::FSM_IDLE;
         valid_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      ts_ff       <= ts_in;
      rd_vld_ff   <= rd_vld_in;
      scan_ff     <= scan_in;
      cmp_addr_ff <= cmp_addr_in;
      cnt_ff      <= cnt_in;
      status_ff   <= status_in;
      holder_ff   <= holder_in;
      count_ff    <= count_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = wdlt_pkg::RSP_DATA_BITS'({count_ff, holder_ff});

endmodule

[hw/rtl/wdlt_checker.sv]
// ----------------------------------------------------------------------------
// wdlt_checker
// Port-level checks for the wait-die lock table, bound to the top level.
// ----------------------------------------------------------------------------
module wdlt_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [wdlt_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic [wdlt_pkg::TYPE_BITS-1:0]       req_tuser,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [wdlt_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic [wdlt_pkg::STATUS_BITS-1:0]     rsp_tuser
);

   localparam int HB = wdlt_pkg::HOLDER_BITS;
   localparam int CB = wdlt_pkg::COUNT_BITS;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous request still in work");

   a_release_no_holder: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == wdlt_pkg::ST_RELEASED |-> rsp_tdata[HB-1:0] == '0)
      else $error("release response carries a holder stamp");

   a_acquire_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != wdlt_pkg::ST_RELEASED |-> rsp_tdata[HB +: CB] == '0)
      else $error("acquire response carries a release count");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind wait_die_lock_table wdlt_checker u_wdlt_checker (.*);
